// ===== design/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// shared codes, widths and state type of the first-fit block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int CFG_W    = 8;
    localparam int SIZE_W   = 8;
    localparam int EXT_ID_W = 16;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DEFRAG = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAIL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ILLEGAL = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ASCAN,
        ST_AFILL,
        ST_ESCAN,
        ST_DSCAN,
        ST_DTAIL,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== design/ffba_mem.sv =====
// ----------------------------------------------------------------------------
// ffba_mem
// cell owner memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16,
    parameter int AW    = 7
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// sequencer: scans the cell memory, fills, frees and compacts, holds result
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl #(
    parameter int CELL_COUNT = 128,
    parameter int ID_BITS    = 16,
    parameter int IDX_W      = 7
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [ffba_pkg::CFG_W-1:0]      cfg_cells,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ffba_pkg::OP_W-1:0]       in_op,
    input  wire logic [ffba_pkg::SIZE_W-1:0]     in_size,
    input  wire logic [ffba_pkg::EXT_ID_W-1:0]   in_id,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [ffba_pkg::STAT_W-1:0]     out_status,
    output logic      [ffba_pkg::EXT_ID_W-1:0]   out_id,
    output logic                                 rd_en,
    output logic      [IDX_W-1:0]                rd_addr,
    input  wire logic [ID_BITS-1:0]              rd_data,
    output logic                                 wr_en,
    output logic      [IDX_W-1:0]                wr_addr,
    output logic      [ID_BITS-1:0]              wr_data
);

    import ffba_pkg::*;

    localparam int CNT_W = $clog2(CELL_COUNT + 1);
    localparam int SZ_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int CMP_W = (ID_BITS > EXT_ID_W) ? ID_BITS : EXT_ID_W;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                pv_reg, pv_next;
    logic [IDX_W-1:0]    p_idx_reg, p_idx_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0]    end_reg, end_next;
    logic                freed_reg, freed_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [EXT_ID_W-1:0] id_reg, id_next;
    logic [STAT_W-1:0]   res_stat_reg, res_stat_next;
    logic [ID_BITS-1:0]  last_id_reg, last_id_next;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;
    logic [EXT_ID_W-1:0] out_id_reg, out_id_next;

    logic [CNT_W-1:0] cnt;
    logic             data_zero;
    logic [CNT_W-1:0] run_inc;
    logic             found;
    logic             id_hit;
    logic             scan_last;
    logic             keep;
    logic [CNT_W-1:0] dst_after;
    logic [CNT_W-1:0] fill_start;
    logic             fill_done;
    logic             clr_last;
    logic             tail_last;
    logic             alloc_bad;
    logic             erase_bad;
    logic             out_free;

    // managed cell count, capped at the built depth
    always_comb
    begin
        if (32'(cfg_cells) > 32'(CELL_COUNT))
        begin
            cnt = CNT_W'(CELL_COUNT);
        end
        else
        begin
            cnt = CNT_W'(cfg_cells);
        end
    end

    always_comb
    begin
        data_zero  = (rd_data == '0);
        run_inc    = data_zero ? (run_reg + CNT_W'(1)) : '0;
        found      = pv_reg && (SZ_W'(run_inc) == SZ_W'(size_reg));
        id_hit     = pv_reg && (CMP_W'(rd_data) == CMP_W'(id_reg));
        scan_last  = pv_reg && (CNT_W'(p_idx_reg) == (cnt - CNT_W'(1)));
        keep       = pv_reg && !data_zero;
        dst_after  = keep ? (ptr_reg + CNT_W'(1)) : ptr_reg;
        fill_start = CNT_W'(p_idx_reg) + CNT_W'(1) - CNT_W'(size_reg);
        fill_done  = (ptr_reg[IDX_W-1:0] == end_reg);
        clr_last   = (ptr_reg[IDX_W-1:0] == IDX_W'(CELL_COUNT - 1));
        tail_last  = (ptr_reg == (cnt - CNT_W'(1)));
        alloc_bad  = (in_size == '0) || (SZ_W'(in_size) > SZ_W'(cnt)) || (&last_id_reg);
        erase_bad  = (in_id == '0) || (cnt == '0);
        out_free   = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_ALLOC:  state_next = alloc_bad ? ST_RESP : ST_ASCAN;
                        OP_ERASE:  state_next = erase_bad ? ST_RESP : ST_ESCAN;
                        OP_DEFRAG: state_next = (cnt == '0) ? ST_IDLE : ST_DSCAN;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ASCAN:
            begin
                if (found)
                begin
                    state_next = ST_AFILL;
                end
                else if (scan_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_AFILL:
            begin
                if (fill_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_ESCAN:
            begin
                if (scan_last)
                begin
                    state_next = (freed_reg || id_hit) ? ST_IDLE : ST_RESP;
                end
            end
            ST_DSCAN:
            begin
                if (scan_last)
                begin
                    state_next = (dst_after < cnt) ? ST_DTAIL : ST_IDLE;
                end
            end
            ST_DTAIL:
            begin
                if (tail_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        rd_idx_next     = rd_idx_reg;
        pv_next         = 1'b0;
        p_idx_next      = p_idx_reg;
        run_next        = run_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        freed_next      = freed_reg;
        size_next       = size_reg;
        id_next         = id_reg;
        res_stat_next   = res_stat_reg;
        last_id_next    = last_id_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = ptr_reg[IDX_W-1:0];
        wr_data         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rd_idx_next   = '0;
                    run_next      = '0;
                    ptr_next      = '0;
                    freed_next    = 1'b0;
                    size_next     = in_size;
                    id_next       = in_id;
                    res_stat_next = (in_op == OP_ALLOC) ? STAT_FAIL : STAT_ILLEGAL;
                end
            end
            ST_ASCAN, ST_ESCAN, ST_DSCAN:
            begin
                rd_en      = (rd_idx_reg < cnt);
                pv_next    = rd_en;
                p_idx_next = rd_idx_reg[IDX_W-1:0];
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (state_reg == ST_ASCAN)
                begin
                    if (pv_reg)
                    begin
                        run_next = run_inc;
                    end
                    if (found)
                    begin
                        last_id_next  = last_id_reg + ID_BITS'(1);
                        ptr_next      = fill_start;
                        end_next      = p_idx_reg;
                        res_stat_next = STAT_OK;
                    end
                end
                else if (state_reg == ST_ESCAN)
                begin
                    if (id_hit)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = p_idx_reg;
                        freed_next = 1'b1;
                    end
                end
                else
                begin
                    if (keep)
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data;
                    end
                    ptr_next = dst_after;
                end
            end
            ST_AFILL:
            begin
                wr_en    = 1'b1;
                wr_data  = last_id_reg;
                ptr_next = ptr_reg + CNT_W'(1);
            end
            ST_DTAIL:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + CNT_W'(1);
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_stat_reg;
                    out_id_next     = (res_stat_reg == STAT_OK) ? EXT_ID_W'(last_id_reg) : '0;
                end
            end
            default:
            begin
                pv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pv_reg        <= 1'b0;
            ptr_reg       <= '0;
            last_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pv_reg        <= pv_next;
            ptr_reg       <= ptr_next;
            last_id_reg   <= last_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        p_idx_reg      <= p_idx_next;
        run_reg        <= run_next;
        end_reg        <= end_next;
        freed_reg      <= freed_next;
        size_reg       <= size_next;
        id_reg         <= id_next;
        res_stat_reg   <= res_stat_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_id     = out_id_reg;

endmodule

`default_nettype wire

// ===== design/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit cell allocator with erase and compaction over one cell memory
// ----------------------------------------------------------------------------
//   channel   direction  signals                      content
//   s_axis    in         tvalid tready tdata tuser    one command item
//   m_axis    out        tvalid tready tdata tuser    one result item
//   cfg       in         valid ready data             cells_in_use write
//
// one item at a time; memory read pipelined one cell a cycle
// alloc: scan the managed cells, fill the found run cell by cell, then post
// erase: scan the managed cells; defragment: scan, then clear the tail
// after reset a clearing pass over all CELL_COUNT cells runs with s_axis_tready low
// a waiting result sits in the output register; a new item is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
    parameter int CELL_COUNT = 128,
    parameter int ID_BITS    = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // alloc_size[7:0], erase_id[23:8]
    input  wire logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // new_id[15:0]
    output logic      [1:0]  m_axis_tuser,   // status[1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data        // cells_in_use[7:0]
);

    import ffba_pkg::*;

    localparam int IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    logic [CFG_W-1:0]   cells_in_use_reg, cells_in_use_next;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ID_BITS-1:0] rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ID_BITS-1:0] wr_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cells_in_use_next = cells_in_use_reg;
        if (cfg_valid && cfg_ready)
        begin
            cells_in_use_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_in_use_reg <= CFG_RESET;
        end
        else
        begin
            cells_in_use_reg <= cells_in_use_next;
        end
    end

    ffba_ctrl #(
        .CELL_COUNT (CELL_COUNT),
        .ID_BITS    (ID_BITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_cells  (cells_in_use_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_size    (s_axis_tdata[7:0]),
        .in_id      (s_axis_tdata[23:8]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_id     (m_axis_tdata),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    ffba_mem #(
        .DEPTH (CELL_COUNT),
        .WIDTH (ID_BITS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire

// ===== design/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// port-level checks of the first-fit block allocator
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [23:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    import ffba_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_FAIL ||
                           m_axis_tuser == STAT_ILLEGAL))
        else $error("undefined status code");

    // failed results carry id zero
    a_fail_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == '0)
        else $error("nonzero id on failed result");

    // alloc and erase keep the block busy right after the item is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
            (s_axis_tuser == OP_ALLOC || s_axis_tuser == OP_ERASE) |=> !s_axis_tready)
        else $error("ready right after alloc or erase item");

    // defragment posts nothing right away
    a_defrag_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_DEFRAG &&
            !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result after defragment item");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

`default_nettype wire

// ===== tb/tb_first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// self-checking bench for the first-fit block allocator: commands are queued
// by a sequencer, driven by a clocked driver with random gaps, and predicted
// by an in-bench model of the cell row; replies from the result stream are
// checked field by field under random and long output stalls, over several
// cells_in_use settings including an empty and a one-cell row
// ----------------------------------------------------------------------------
`default_nettype none

module tb_first_fit_block_allocator;

    import ffba_pkg::*;

    localparam int                  CELLS         = 128;
    localparam logic [EXT_ID_W-1:0] ID_CEILING    = 16'hFFFF;
    localparam logic [OP_W-1:0]     OP_NONE       = 2'd3;
    localparam int                  SETTLE_CYCLES = 2 * CELLS + 48;
    localparam int                  STALL_LIMIT   = 6000;
    localparam int                  LONG_HOLD     = 400;
    localparam int                  REPORT_CAP    = 200;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SIZE_W-1:0]   size;
        logic [EXT_ID_W-1:0] block_id;
        logic                drain;
    } command_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [EXT_ID_W-1:0] block_id;
    } reply_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // alloc_size[7:0], erase_id[23:8]
    logic [1:0]  s_axis_tuser  = '0;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // new_id[15:0]
    logic [1:0]  m_axis_tuser;         // status[1:0]
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data      = '0;   // cells_in_use[7:0]

    // allocator model state
    logic [EXT_ID_W-1:0] owner_map [CELLS];
    logic [EXT_ID_W-1:0] last_issued_id = '0;
    logic [CFG_W-1:0]    managed_reg    = CFG_RESET;

    command_t pending_cmds [$];
    reply_t   expected_replies [$];

    int results_owed    = 0;
    int items_sent      = 0;
    int replies_checked = 0;
    int cfg_writes      = 0;
    int error_count     = 0;
    int src_gap         = 0;
    int snk_gap         = 0;
    int hold_left       = 0;
    int hold_at_item    = 0;
    int idle_cycles     = 0;
    bit src_drain_wait  = 1'b0;
    bit hold_fired      = 1'b0;
    bit src_gaps_on     = 1'b0;
    bit snk_stalls_on   = 1'b0;

    first_fit_block_allocator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one command applied to the cell row; returns the reply it causes
    function automatic void apply_command(input command_t c, output bit has_reply,
                                          output reply_t r);
        int  count;
        int  run;
        int  dst;
        int  i;
        int  k;
        bit  found;
        bit  freed;
        count     = (managed_reg > CELLS) ? CELLS : managed_reg;
        has_reply = 1'b0;
        r.status   = STAT_FAIL;
        r.block_id = '0;
        case (c.op)
            OP_ALLOC:
            begin
                has_reply = 1'b1;
                run       = 0;
                found     = 1'b0;
                if (c.size != 0 && c.size <= count && last_issued_id != ID_CEILING)
                begin
                    for (i = 0; i < count; i++)
                    begin
                        if (!found)
                        begin
                            run = (owner_map[i] == '0) ? run + 1 : 0;
                            if (run == c.size)
                            begin
                                last_issued_id = last_issued_id + 1'b1;
                                for (k = i + 1 - run; k <= i; k++)
                                    owner_map[k] = last_issued_id;
                                r.status   = STAT_OK;
                                r.block_id = last_issued_id;
                                found      = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_ERASE:
            begin
                freed = 1'b0;
                if (c.block_id != '0)
                begin
                    for (i = 0; i < count; i++)
                    begin
                        if (owner_map[i] == c.block_id)
                        begin
                            owner_map[i] = '0;
                            freed        = 1'b1;
                        end
                    end
                end
                if (!freed)
                begin
                    has_reply = 1'b1;
                    r.status  = STAT_ILLEGAL;
                end
            end
            OP_DEFRAG:
            begin
                dst = 0;
                for (i = 0; i < count; i++)
                begin
                    if (owner_map[i] != '0)
                    begin
                        owner_map[dst] = owner_map[i];
                        dst++;
                    end
                end
                for (i = dst; i < count; i++)
                    owner_map[i] = '0;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        error_count++;
        if (error_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin : command_drive
        command_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid  <= 1'b0;
            s_axis_tdata   <= '0;
            s_axis_tuser   <= '0;
            src_gap        <= 0;
            src_drain_wait <= 1'b0;
            items_sent     <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                items_sent <= items_sent + 1;
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap != 0)
                begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (pending_cmds[0].drain && !src_drain_wait)
                begin
                    src_drain_wait <= 1'b1;
                    s_axis_tvalid  <= 1'b0;
                end
                else if (pending_cmds[0].drain && results_owed != 0)
                    s_axis_tvalid <= 1'b0;
                else
                begin
                    nxt            = pending_cmds.pop_front();
                    s_axis_tvalid  <= 1'b1;
                    s_axis_tdata   <= {nxt.block_id, nxt.size};
                    s_axis_tuser   <= nxt.op;
                    src_drain_wait <= 1'b0;
                    src_gap        <= src_gaps_on ? gap_length() : 0;
                end
            end
        end
    end

    // result receiver, with random stalls and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            snk_gap       <= 0;
            hold_left     <= 0;
            hold_fired    <= 1'b0;
        end
        else if (!hold_fired && hold_at_item != 0 && items_sent == hold_at_item)
        begin
            hold_fired    <= 1'b1;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (snk_gap != 0)
        begin
            snk_gap       <= snk_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (snk_stalls_on && $urandom_range(0, 4) == 0)
                snk_gap <= gap_length();
        end
    end

    // prediction at command accept, check at reply accept
    always @(posedge clk)
    begin : reply_check
        command_t taken;
        reply_t   want;
        reply_t   got;
        bit       has_reply;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status   = m_axis_tuser;
                got.block_id = m_axis_tdata;
                if (expected_replies.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                        $display("%0t: unexpected reply, expected none, actual status %0d id %0d",
                                 $time, got.status, got.block_id);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    replies_checked++;
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.block_id !== want.block_id)
                        report_mismatch("new_id", want.block_id, got.block_id);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken.op       = s_axis_tuser;
                taken.size     = s_axis_tdata[7:0];
                taken.block_id = s_axis_tdata[23:8];
                taken.drain    = 1'b0;
                apply_command(taken, has_reply, want);
                if (has_reply)
                    expected_replies.push_back(want);
            end
            if (cfg_valid && cfg_ready)
                managed_reg = cfg_data;
            results_owed <= expected_replies.size();
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_cmd(input logic [OP_W-1:0] op, input int size, input int id,
                            input bit drain);
        command_t c;
        c.op       = op;
        c.size     = size[SIZE_W-1:0];
        c.block_id = id[EXT_ID_W-1:0];
        c.drain    = drain;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || results_owed != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cells(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(negedge clk);
    endtask

    function automatic int recent_id();
        int span;
        span = $urandom_range(0, 12);
        if (last_issued_id > span)
            return last_issued_id - span;
        return 1;
    endfunction

    task automatic random_phase(input logic [CFG_W-1:0] cells_value, input int n);
        int       count;
        int       small_lim;
        int       pick;
        int       sub;
        command_t c;
        wait_idle();
        write_cells(cells_value);
        count     = (cells_value > CELLS) ? CELLS : cells_value;
        small_lim = (count < 12) ? count : 12;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                src_gaps_on   = ($urandom_range(0, 3) != 0);
                snk_stalls_on = ($urandom_range(0, 3) != 0);
            end
            while (pending_cmds.size() >= 4)
                @(negedge clk);
            c.size     = SIZE_W'($urandom_range(0, 255));
            c.block_id = EXT_ID_W'($urandom_range(0, 65535));
            c.drain    = ($urandom_range(0, 49) == 0);
            pick       = $urandom_range(0, 99);
            sub        = $urandom_range(0, 99);
            if (pick < 50)
            begin
                c.op = OP_ALLOC;
                if (sub < 70)
                    c.size = SIZE_W'($urandom_range(1, small_lim));
                else if (sub < 85)
                    c.size = SIZE_W'($urandom_range(1, count));
                else if (sub >= 94)
                    c.size = SIZE_W'(count + $urandom_range(0, 1));
            end
            else if (pick < 85)
            begin
                c.op = OP_ERASE;
                if (sub < 80)
                    c.block_id = EXT_ID_W'(recent_id());
                else if (sub < 88)
                    c.block_id = '0;
            end
            else if (pick < 97)
                c.op = OP_DEFRAG;
            else
                c.op = OP_NONE;
            pending_cmds.push_back(c);
        end
    endtask

    initial
    begin : sequencer
        foreach (owner_map[i])
            owner_map[i] = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        // covers the clearing pass after reset
        repeat (SETTLE_CYCLES) @(negedge clk);

        // count above the row size is capped
        write_cells(8'd255);
        push_cmd(OP_ALLOC, 0, 0, 0);
        push_cmd(OP_ALLOC, 255, 0, 0);
        push_cmd(OP_ALLOC, 129, 0, 0);
        push_cmd(OP_ALLOC, 128, 0, 0);
        push_cmd(OP_ALLOC, 1, 0, 0);
        push_cmd(OP_ERASE, 0, 0, 0);
        push_cmd(OP_ERASE, 0, 65535, 0);
        push_cmd(OP_ERASE, 0, 1, 0);
        push_cmd(OP_ALLOC, 1, 0, 0);
        push_cmd(OP_ALLOC, 3, 0, 0);
        push_cmd(OP_ALLOC, 2, 0, 0);
        push_cmd(OP_ERASE, 0, 3, 0);
        push_cmd(OP_ALLOC, 4, 0, 0);
        push_cmd(OP_DEFRAG, 0, 0, 0);
        push_cmd(OP_NONE, 255, 65535, 0);
        push_cmd(OP_ERASE, 0, 3, 0);
        push_cmd(OP_ALLOC, 121, 0, 0);
        push_cmd(OP_ALLOC, 1, 0, 0);

        // nothing managed
        wait_idle();
        write_cells(8'd0);
        push_cmd(OP_ALLOC, 1, 0, 0);
        push_cmd(OP_ERASE, 0, 2, 0);
        push_cmd(OP_DEFRAG, 0, 0, 0);

        // single managed cell, the rest of the row stays untouched
        wait_idle();
        write_cells(8'd1);
        push_cmd(OP_ERASE, 0, 2, 0);
        push_cmd(OP_ALLOC, 1, 0, 0);
        push_cmd(OP_ALLOC, 2, 0, 0);

        random_phase(8'd128, 190);

        // output held off while commands keep coming, then sender drains
        wait_idle();
        write_cells(8'd128);
        src_gaps_on   = 1'b0;
        snk_stalls_on = 1'b0;
        hold_at_item  = items_sent + 2;
        repeat (12) push_cmd(OP_ALLOC, 1, 0, 0);
        push_cmd(OP_ALLOC, 2, 0, 1);
        push_cmd(OP_DEFRAG, 0, 0, 0);

        random_phase(8'd1, 180);
        random_phase(8'd40, 180);
        random_phase(8'd255, 180);
        random_phase(8'd8, 180);
        random_phase(CFG_W'($urandom_range(2, 127)), 180);

        // full one-cell row, erase of an id never handed out, zero size
        wait_idle();
        write_cells(8'd1);
        src_gaps_on   = 1'b0;
        snk_stalls_on = 1'b0;
        if (owner_map[0] != '0)
            push_cmd(OP_ERASE, 0, owner_map[0], 0);
        push_cmd(OP_ALLOC, 1, 0, 0);
        push_cmd(OP_ALLOC, 1, 0, 0);
        push_cmd(OP_ERASE, 0, ID_CEILING, 0);
        push_cmd(OP_ALLOC, 1, 0, 0);
        push_cmd(OP_ALLOC, 0, 0, 0);
        wait_idle();
        write_cells(8'd128);
        src_gaps_on   = 1'b1;
        snk_stalls_on = 1'b1;
        push_cmd(OP_ALLOC, 3, 0, 0);
        push_cmd(OP_DEFRAG, 0, 0, 0);
        push_cmd(OP_ERASE, 0, ID_CEILING, 0);
        push_cmd(OP_ERASE, 0, 0, 0);

        wait_idle();
        if (expected_replies.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected replies never arrived", $time, expected_replies.size());
        end
        $display("covered %0d commands and %0d checked replies over %0d cells_in_use writes",
                 items_sent, replies_checked, cfg_writes);
        $display("ids handed out up to %0d, with a long output hold-off and drained input",
                 last_issued_id);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
